/* src/udlc_pkg.sv */
`default_nettype none

package udlc_pkg;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = 2;
  localparam int TDATA_W    = 40;

  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_AT    = 8'h40;

  localparam logic [3:0] CLS_PREAMBLE = 4'd0;
  localparam logic [3:0] CLS_FROM     = 4'd1;
  localparam logic [3:0] CLS_TO       = 4'd2;
  localparam logic [3:0] CLS_HUNK     = 4'd3;
  localparam logic [3:0] CLS_CONTEXT  = 4'd4;
  localparam logic [3:0] CLS_ADD      = 4'd5;
  localparam logic [3:0] CLS_DEL      = 4'd6;
  localparam logic [3:0] CLS_NOTE     = 4'd7;
  localparam logic [3:0] CLS_ERROR    = 4'd8;

  localparam logic [1:0] MODE_PREAMBLE  = 2'd0;
  localparam logic [1:0] MODE_EXP_TO    = 2'd1;
  localparam logic [1:0] MODE_EXP_HUNK  = 2'd2;
  localparam logic [1:0] MODE_IN_HUNK   = 2'd3;

  localparam int         PFX_LEN   = 4;
  localparam logic [2:0] PFX_DONE  = 3'd4;
  localparam logic [2:0] PFX_FAIL  = 3'd7;
  localparam int         NOTE_LEN  = 27;
  localparam logic [4:0] NOTE_DONE = 5'd27;
  localparam logic [4:0] NOTE_FAIL = 5'd31;
  localparam logic [4:0] HH_DONE   = 5'd15;
  localparam logic [4:0] HH_FAIL   = 5'd31;

  localparam logic [PFX_LEN*8-1:0]  MINUS_TEXT = "--- ";
  localparam logic [PFX_LEN*8-1:0]  PLUS_TEXT  = "+++ ";
  localparam logic [NOTE_LEN*8-1:0] NOTE_TEXT  = "\\ No newline at end of file";

  typedef struct packed {
    logic       done;
    logic       last;
    logic [1:0] mode;
    logic [31:0] num;
    logic [3:0] cls;
  } res_t;

  function automatic logic [2:0] pfx_adv(input logic [2:0] pos,
                                         input logic [PFX_LEN*8-1:0] txt,
                                         input logic [7:0] c);
    logic [7:0] ch;
    ch = 8'd0;
    if (pos >= PFX_DONE) begin
      return pos;
    end
    ch = txt[8*(PFX_LEN-1-int'(pos)) +: 8];
    return (ch == c) ? 3'(pos + 3'd1) : PFX_FAIL;
  endfunction

  function automatic logic [4:0] note_adv(input logic [4:0] pos, input logic [7:0] c);
    logic [7:0] ch;
    ch = 8'd0;
    if (pos >= NOTE_DONE) begin
      return pos;
    end
    ch = NOTE_TEXT[8*(NOTE_LEN-1-int'(pos)) +: 8];
    return (ch == c) ? 5'(pos + 5'd1) : NOTE_FAIL;
  endfunction

  function automatic logic [4:0] hunk_adv(input logic [4:0] ph, input logic [7:0] c);
    logic d;
    logic [4:0] r;
    d = (c >= "0") && (c <= "9");
    case (ph)
      5'd0, 5'd1, 5'd13, 5'd14: r = (c == CH_AT) ? 5'(ph + 5'd1) : HH_FAIL;
      5'd2:  r = (c == CH_SPACE) ? 5'd3 : HH_FAIL;
      5'd3:  r = (c == CH_MINUS) ? 5'd4 : HH_FAIL;
      5'd4:  r = d ? 5'd5 : HH_FAIL;
      5'd5:  r = d ? 5'd5 : (c == CH_COMMA) ? 5'd6 : (c == CH_SPACE) ? 5'd8 : HH_FAIL;
      5'd6:  r = d ? 5'd7 : HH_FAIL;
      5'd7:  r = d ? 5'd7 : (c == CH_SPACE) ? 5'd8 : HH_FAIL;
      5'd8:  r = (c == CH_PLUS) ? 5'd9 : HH_FAIL;
      5'd9:  r = d ? 5'd10 : HH_FAIL;
      5'd10: r = d ? 5'd10 : (c == CH_COMMA) ? 5'd11 : (c == CH_SPACE) ? 5'd13 : HH_FAIL;
      5'd11: r = d ? 5'd12 : HH_FAIL;
      5'd12: r = d ? 5'd12 : (c == CH_SPACE) ? 5'd13 : HH_FAIL;
      HH_DONE: r = HH_DONE;
      default: r = HH_FAIL;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

/* src/unified_diff_line_classifier.sv */
// With the queue empty, a result shows on out_tvalid in the cycle after its byte; a held
// "--- " line in a hunk is only resolved by a byte of the next line.
// Throughput: one byte per cycle while out_tready is high and each byte causes at most one
// result; a byte that causes two results (held dash line resolved as the next line ends)
// writes both together into a four-entry result queue, which absorbs the extra result.
// Reset (rst_n low, synchronous) empties the queue and returns the parser to preamble mode.
`default_nettype none

module unified_diff_line_classifier
  import udlc_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_tvalid,
  output logic                    in_tready,
  input  wire logic [7:0]         in_tdata,   // [7:0] data_byte
  input  wire logic               in_tlast,   // end_of_input
  output logic                    out_tvalid,
  input  wire logic               out_tready,
  output logic [TDATA_W-1:0]      out_tdata,  // [3:0] line_class, [35:4] line_number,
                                              // [37:36] mode_after, zero above
  output logic                    out_tlast,  // run_last
  output logic                    out_tuser   // text_done
);

  logic [1:0]  mode_r, mode_nxt;
  logic        pend_r, pend_nxt;
  logic [2:0]  mp_r, mp_nxt;
  logic [2:0]  pp_r, pp_nxt;
  logic [4:0]  np_r, np_nxt;
  logic [4:0]  hp_r, hp_nxt;
  logic [7:0]  fc_r, fc_nxt;
  logic        hb_r, hb_nxt;
  logic [31:0] cnt_r, cnt_nxt;

  res_t                 fifo_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [FIFO_AW:0]     fcnt_r;

  logic        acc, pop, nl, eoi;
  logic [7:0]  c;
  logic        r0_v, r1_v;
  res_t        r0, r1, w0;
  logic [1:0]  push_n;

  assign c   = in_tdata;
  assign eoi = in_tlast;
  assign nl  = (c == CH_NL);
  assign acc = in_tvalid && in_tready;
  assign pop = out_tvalid && out_tready;

  assign in_tready  = (fcnt_r <= (FIFO_AW+1)'(FIFO_DEPTH - 2));
  assign out_tvalid = (fcnt_r != '0);
  assign out_tdata  = {{(TDATA_W-38){1'b0}}, fifo_r[rd_ptr_r].mode,
                       fifo_r[rd_ptr_r].num, fifo_r[rd_ptr_r].cls};
  assign out_tlast  = fifo_r[rd_ptr_r].last;
  assign out_tuser  = fifo_r[rd_ptr_r].done;

  always_comb begin
    logic [2:0]  mp, pp;
    logic [4:0]  np, hp;
    logic [7:0]  fc;
    logic        hb, minus, hh, hold;
    logic [1:0]  md;
    logic [3:0]  cls;
    logic [31:0] cn;
    mp = mp_r;
    pp = pp_r;
    np = np_r;
    hp = hp_r;
    fc = fc_r;
    hb = hb_r;
    md = mode_r;
    cn = cnt_r;
    minus = 1'b0;
    hh = 1'b0;
    hold = 1'b0;
    cls = CLS_PREAMBLE;
    r0 = '0;
    r1 = '0;
    r0_v = 1'b0;
    r1_v = 1'b0;
    pend_nxt = pend_r;
    if (!nl) begin
      if (!hb_r) begin
        fc = c;
      end
      hb = 1'b1;
      mp = pfx_adv(mp_r, MINUS_TEXT, c);
      pp = pfx_adv(pp_r, PLUS_TEXT, c);
      np = note_adv(np_r, c);
      hp = hunk_adv(hp_r, c);
    end

    if (pend_r) begin
      if (pp == PFX_DONE) begin
        md = MODE_EXP_TO;
        r0_v = 1'b1;
        r0.cls = CLS_FROM;
        pend_nxt = 1'b0;
      end else if (pp == PFX_FAIL || nl || eoi) begin
        r0_v = 1'b1;
        r0.cls = CLS_DEL;
        pend_nxt = 1'b0;
      end
      r0.num  = cnt_r;
      r0.mode = md;
    end

    if (nl || eoi) begin
      minus = (mp == PFX_DONE);
      hh    = (hp == HH_DONE);
      if (cnt_r != '1) begin
        cn = cnt_r + 32'd1;
      end
      case (md)
        MODE_PREAMBLE: begin
          if (minus) begin
            cls = CLS_FROM;
            md = MODE_EXP_TO;
          end else begin
            cls = CLS_PREAMBLE;
          end
        end
        MODE_EXP_TO: begin
          if (pp == PFX_DONE) begin
            cls = CLS_TO;
            md = MODE_EXP_HUNK;
          end else begin
            cls = CLS_ERROR;
          end
        end
        MODE_EXP_HUNK: begin
          if (hh) begin
            cls = CLS_HUNK;
            md = MODE_IN_HUNK;
          end else if (minus) begin
            cls = CLS_FROM;
            md = MODE_EXP_TO;
          end else begin
            cls = CLS_ERROR;
          end
        end
        default: begin
          if (hh) cls = CLS_HUNK;
          else if (minus && nl && !eoi) hold = 1'b1;
          else if (hb && fc == CH_SPACE) cls = CLS_CONTEXT;
          else if (hb && fc == CH_PLUS) cls = CLS_ADD;
          else if (hb && fc == CH_MINUS) cls = CLS_DEL;
          else if (np == NOTE_DONE) cls = CLS_NOTE;
          else cls = CLS_ERROR;
        end
      endcase
      if (hold) begin
        pend_nxt = 1'b1;
      end else begin
        r1_v = 1'b1;
        r1.cls  = cls;
        r1.num  = cn;
        r1.mode = md;
      end
      mp = '0;
      pp = '0;
      np = '0;
      hp = '0;
      fc = '0;
      hb = 1'b0;
    end

    r1.last = 1'b1;
    r1.done = eoi;
    r0.last = !r1_v;
    r0.done = eoi && !r1_v;

    if (eoi) begin
      mode_nxt = MODE_PREAMBLE;
      pend_nxt = 1'b0;
      cnt_nxt  = '0;
    end else begin
      mode_nxt = md;
      cnt_nxt  = cn;
    end
    mp_nxt = mp;
    pp_nxt = pp;
    np_nxt = np;
    hp_nxt = hp;
    fc_nxt = fc;
    hb_nxt = hb;
  end

  assign w0     = r0_v ? r0 : r1;
  assign push_n = acc ? (2'(r0_v) + 2'(r1_v)) : 2'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= MODE_PREAMBLE;
      pend_r   <= 1'b0;
      mp_r     <= '0;
      pp_r     <= '0;
      np_r     <= '0;
      hp_r     <= '0;
      fc_r     <= '0;
      hb_r     <= 1'b0;
      cnt_r    <= '0;
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fcnt_r   <= '0;
    end else begin
      if (acc) begin
        mode_r <= mode_nxt;
        pend_r <= pend_nxt;
        mp_r   <= mp_nxt;
        pp_r   <= pp_nxt;
        np_r   <= np_nxt;
        hp_r   <= hp_nxt;
        fc_r   <= fc_nxt;
        hb_r   <= hb_nxt;
        cnt_r  <= cnt_nxt;
      end
      wr_ptr_r <= wr_ptr_r + FIFO_AW'(push_n);
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + FIFO_AW'(1);
      end
      fcnt_r <= fcnt_r + (FIFO_AW+1)'(push_n) - (FIFO_AW+1)'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push_n != 2'd0) begin
      fifo_r[wr_ptr_r] <= w0;
    end
    if (push_n == 2'd2) begin
      fifo_r[wr_ptr_r + FIFO_AW'(1)] <= r1;
    end
  end

  a_fifo_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fcnt_r <= (FIFO_AW+1)'(FIFO_DEPTH))
    else $error("result queue overfilled");

  a_pend_in_hunk: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r |-> (mode_r == MODE_IN_HUNK))
    else $error("dash line held outside a hunk");

  a_eoi_reset: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && eoi) |=> (mode_r == MODE_PREAMBLE && cnt_r == '0 && !pend_r && !hb_r))
    else $error("parser state not cleared after end of text");

  a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser) |-> out_tlast)
    else $error("text end flagged on a result that is not last of its byte");

endmodule

`default_nettype wire
